### src/nrfe_pkg.sv
// Shared types and constants for the RMC field extractor.
// No dependencies.
package nrfe_pkg;

	// parse phases of one sentence
	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_FIXED  = 3'd1,
		PH_SPEED  = 3'd2,
		PH_COURSE = 3'd3,
		PH_DATE   = 3'd4
	} phase_t;

	// field tags on the result beat
	localparam logic [2:0] FIELD_TIME  = 3'd0;
	localparam logic [2:0] FIELD_LAT   = 3'd1;
	localparam logic [2:0] FIELD_LON   = 3'd2;
	localparam logic [2:0] FIELD_SPEED = 3'd3;
	localparam logic [2:0] FIELD_DATE  = 3'd4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// offsets counted from the '$'
	localparam logic [6:0] OFF_HDR_END   = 7'd3;
	localparam logic [6:0] OFF_TIME_LO   = 7'd7;
	localparam logic [6:0] OFF_TIME_HI   = 7'd15;
	localparam logic [6:0] OFF_LAT_LO    = 7'd19;
	localparam logic [6:0] OFF_LAT_HI    = 7'd28;
	localparam logic [6:0] OFF_LON_LO    = 7'd32;
	localparam logic [6:0] OFF_LON_HI    = 7'd42;
	localparam logic [6:0] OFF_SPEED     = 7'd46;
	localparam logic [6:0] OFF_MAX       = 7'd127;

	localparam logic [3:0] SPEED_MAX_CHARS = 4'd7;
	localparam logic [3:0] DATE_LAST_POS   = 4'd5;

endpackage

### src/nmea_rmc_field_extractor_core.sv
// RMC sentence field extractor: header hunt, offset tracking, tagged char output.
// Depends on nrfe_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | input     | in_valid/in_stall   | rx_byte
//  out     | output    | out_valid/out_stall | field_code, char_position, char_value,
//          |           |                    | sentence_done, speed_overflow
//
// One byte per cycle sustained unless out_stall holds the result register. A byte is held
// in the input register and then decoded into the result register.
// Bytes that yield no result still pass the input register and leave no beat.
// in_stall rises only when the input register is full and the result register is
// held by out_stall. Reset puts the parser back to hunting for '$'.
module nmea_rmc_field_extractor_core
	import nrfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] field_code,
	output logic [3:0] char_position,
	output logic [7:0] char_value,
	output logic       sentence_done,
	output logic       speed_overflow
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	phase_t     phase_q, phase_d;
	logic [1:0] hdr_q, hdr_d;
	logic [6:0] offset_q, offset_d;
	logic [3:0] count_q, count_d;
	logic       too_long_q, too_long_d;

	logic       emit;
	logic [2:0] code_c;
	logic [3:0] pos_c;
	logic       done_c;
	logic [6:0] off_inc;

	logic       out_free;
	logic       advance;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign off_inc = (offset_q == OFF_MAX) ? OFF_MAX : offset_q + 7'd1;

	// next state and result for the byte in the input register
	always_comb begin
		phase_d    = phase_q;
		hdr_d      = hdr_q;
		offset_d   = offset_q;
		count_d    = count_q;
		too_long_d = too_long_q;
		emit       = 1'b0;
		code_c     = FIELD_TIME;
		pos_c      = 4'd0;
		done_c     = 1'b0;
		unique case (phase_q)
			PH_FIXED: begin
				offset_d = off_inc;
				if (off_inc >= OFF_TIME_LO && off_inc <= OFF_TIME_HI) begin
					emit  = 1'b1;
					pos_c = 4'(off_inc - OFF_TIME_LO);
				end else if (off_inc >= OFF_LAT_LO && off_inc <= OFF_LAT_HI) begin
					emit   = 1'b1;
					code_c = FIELD_LAT;
					pos_c  = 4'(off_inc - OFF_LAT_LO);
				end else if (off_inc >= OFF_LON_LO && off_inc <= OFF_LON_HI) begin
					emit   = 1'b1;
					code_c = FIELD_LON;
					pos_c  = 4'(off_inc - OFF_LON_LO);
				end else if (off_inc >= OFF_SPEED) begin
					// first speed byte goes out at position zero; count then starts at one
					if (byte_s1 == CH_COMMA) begin
						phase_d = PH_COURSE;
						count_d = 4'd0;
					end else begin
						phase_d = PH_SPEED;
						emit    = 1'b1;
						code_c  = FIELD_SPEED;
						count_d = 4'd1;
					end
				end
			end
			PH_SPEED: begin
				if (byte_s1 == CH_COMMA) begin
					phase_d = PH_COURSE;
					count_d = 4'd0;
				end else if (count_q < SPEED_MAX_CHARS) begin
					emit    = 1'b1;
					code_c  = FIELD_SPEED;
					pos_c   = count_q;
					count_d = count_q + 4'd1;
				end else begin
					too_long_d = 1'b1;
				end
			end
			PH_COURSE: begin
				if (byte_s1 == CH_COMMA) begin
					phase_d = PH_DATE;
					count_d = 4'd0;
				end
			end
			PH_DATE: begin
				emit   = 1'b1;
				code_c = FIELD_DATE;
				if (count_q >= DATE_LAST_POS) begin
					pos_c    = DATE_LAST_POS;
					done_c   = 1'b1;
					phase_d  = PH_HUNT;
					hdr_d    = 2'd0;
					offset_d = 7'd0;
					count_d  = 4'd0;
				end else begin
					pos_c   = count_q;
					count_d = count_q + 4'd1;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				if (hdr_q == 2'd1 && byte_s1 == CH_G) begin
					hdr_d = 2'd2;
				end else if (hdr_q == 2'd2 && byte_s1 == CH_N) begin
					hdr_d = 2'd3;
				end else if (hdr_q == 2'd3 && byte_s1 == CH_R) begin
					hdr_d      = 2'd0;
					phase_d    = PH_FIXED;
					offset_d   = OFF_HDR_END;
					count_d    = 4'd0;
					too_long_d = 1'b0;
				end else begin
					hdr_d = (byte_s1 == CH_DOLLAR) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			hdr_q      <= 2'd0;
			offset_q   <= 7'd0;
			count_q    <= 4'd0;
			too_long_q <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			hdr_q      <= hdr_d;
			offset_q   <= offset_d;
			count_q    <= count_d;
			too_long_q <= too_long_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && emit) begin
			field_code     <= code_c;
			char_position  <= pos_c;
			char_value     <= byte_s1;
			sentence_done  <= done_c;
			speed_overflow <= too_long_q;
		end
	end

	a_done_is_last_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sentence_done |-> field_code == FIELD_DATE && char_position == DATE_LAST_POS)
		else $error("sentence_done on a beat that is not the last date char");

	a_speed_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_code == FIELD_SPEED |-> char_position < SPEED_MAX_CHARS)
		else $error("speed char position beyond limit");

	a_done_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && done_c |=> phase_q == PH_HUNT && offset_q == 7'd0)
		else $error("parser did not return to hunting after sentence end");

	a_fixed_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIXED |-> offset_q >= OFF_HDR_END && offset_q < OFF_SPEED)
		else $error("offset out of range in fixed-field phase");

	a_field_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_code <= FIELD_DATE)
		else $error("field code out of range");

endmodule
